### design/wcf_pkg.sv
// ============================================================================
// wcf_pkg
// Shared types, constants and the CRC-16 XModem byte update for the framer.
// ============================================================================
`default_nettype none

package wcf_pkg;

    localparam logic [7:0]  FRAME_START   = 8'h7E;
    localparam logic [7:0]  FRAME_ZERO    = 8'h00;
    localparam logic [7:0]  FRAME_TYPE_WR = 8'h08;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] CRC_INIT      = 16'h0000;
    localparam logic [8:0]  MAX_PAYLOAD   = 9'd256;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // One accepted payload beat, already classified by the front end.
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [7:0]  len_byte;
        logic [15:0] target_address;
        logic        open_frame;
        logic        close_frame;
    } wcf_cmd_t;

    typedef enum logic [3:0] {
        ST_BEGIN,
        ST_START,
        ST_ZERO,
        ST_TYPE,
        ST_LEN,
        ST_ADDR_HI,
        ST_ADDR_LO,
        ST_DATA,
        ST_CRC_HI,
        ST_CRC_LO
    } wcf_step_t;

    // MSB-first CRC-16 with polynomial 0x1021, one byte per call.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### design/wcf_channels.sv
// ============================================================================
// wcf channels
// Valid/ready interfaces for the payload input and the frame byte output.
// ============================================================================
`default_nettype none

interface wcf_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic [8:0]  frame_length;
    logic [15:0] target_address;

    modport source (output valid, output payload_byte, output frame_length,
                    output target_address, input ready);
    modport sink   (input valid, input payload_byte, input frame_length,
                    input target_address, output ready);
endinterface

interface wcf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;

    modport source (output valid, output out_byte, output run_last,
                    output frame_end, input ready);
    modport sink   (input valid, input out_byte, input run_last,
                    input frame_end, output ready);
endinterface

`default_nettype wire

### design/wcf_front.sv
// ============================================================================
// wcf_front
// Accepts payload beats, tracks the open frame and classifies each beat.
// ============================================================================
`default_nettype none

module wcf_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    wcf_in_if.sink                  data_chan,
    input  wire logic               queue_full,
    output wcf_pkg::wcf_cmd_t       cmd,
    output logic                    push,
    output logic                    frame_open
);
    import wcf_pkg::*;

    logic [8:0] remaining_reg;
    logic [8:0] remaining_next;
    logic [8:0] len_clamped;
    logic [8:0] count_after;
    logic       opening;

    assign data_chan.ready = !queue_full;
    assign push            = data_chan.valid && !queue_full;
    assign opening         = (remaining_reg == 9'd0);
    assign frame_open      = !opening;

    always_comb
    begin
        priority if (data_chan.frame_length == 9'd0)
            len_clamped = 9'd1;
        else if (data_chan.frame_length > MAX_PAYLOAD)
            len_clamped = MAX_PAYLOAD;
        else
            len_clamped = data_chan.frame_length;
    end

    assign count_after    = (opening ? len_clamped : remaining_reg) - 9'd1;
    assign remaining_next = push ? count_after : remaining_reg;

    always_comb
    begin
        cmd.payload_byte   = data_chan.payload_byte;
        cmd.len_byte       = len_clamped[7:0];
        cmd.target_address = data_chan.target_address;
        cmd.open_frame     = opening;
        cmd.close_frame    = (count_after == 9'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            remaining_reg <= 9'd0;
        else
            remaining_reg <= remaining_next;
    end

endmodule

`default_nettype wire

### design/wcf_cmd_fifo.sv
// ============================================================================
// wcf_cmd_fifo
// Short queue of classified beats between the front end and the sequencer.
// ============================================================================
`default_nettype none

module wcf_cmd_fifo #(
    parameter int DEPTH = wcf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire wcf_pkg::wcf_cmd_t  push_cmd,
    input  wire logic               pop,
    output wcf_pkg::wcf_cmd_t       head,
    output logic                    empty,
    output logic                    full
);
    import wcf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wcf_cmd_t           store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign empty   = (count_reg == CNT_W'(0));
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

### design/wcf_back.sv
// ============================================================================
// wcf_back
// Frame sequencer: expands each queued beat into header, data and CRC bytes.
// ============================================================================
`default_nettype none

module wcf_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire wcf_pkg::wcf_cmd_t  head,
    input  wire logic               empty,
    output logic                    pop,
    wcf_out_if.source               frame_chan
);
    import wcf_pkg::*;

    wcf_step_t   step_reg;
    wcf_step_t   step_next;
    wcf_step_t   cur_step;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        valid_reg;
    logic        valid_next;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic        end_reg;
    logic [7:0]  emit_byte;
    logic        emit_last;
    logic        emit_end;
    logic        advance;
    logic        emit;

    assign advance = !valid_reg || frame_chan.ready;
    assign emit    = advance && !empty;
    assign pop     = emit && emit_last;

    // A fresh command starts either at the frame header or at its data byte.
    assign cur_step = (step_reg == ST_BEGIN) ? (head.open_frame ? ST_START : ST_DATA)
                                             : step_reg;

    always_comb
    begin
        step_next = step_reg;
        if (emit)
        begin
            unique case (cur_step)
                ST_START:   step_next = ST_ZERO;
                ST_ZERO:    step_next = ST_TYPE;
                ST_TYPE:    step_next = ST_LEN;
                ST_LEN:     step_next = ST_ADDR_HI;
                ST_ADDR_HI: step_next = ST_ADDR_LO;
                ST_ADDR_LO: step_next = ST_DATA;
                ST_DATA:    step_next = head.close_frame ? ST_CRC_HI : ST_BEGIN;
                ST_CRC_HI:  step_next = ST_CRC_LO;
                default:    step_next = ST_BEGIN;
            endcase
        end
    end

    always_comb
    begin
        emit_last = 1'b0;
        emit_end  = 1'b0;
        crc_next  = crc_reg;
        unique case (cur_step)
            ST_START:   emit_byte = FRAME_START;
            ST_ZERO:    emit_byte = FRAME_ZERO;
            ST_TYPE:
            begin
                emit_byte = FRAME_TYPE_WR;
                crc_next  = crc_feed(CRC_INIT, FRAME_TYPE_WR);
            end
            ST_LEN:
            begin
                emit_byte = head.len_byte;
                crc_next  = crc_feed(crc_reg, head.len_byte);
            end
            ST_ADDR_HI:
            begin
                emit_byte = head.target_address[15:8];
                crc_next  = crc_feed(crc_reg, head.target_address[15:8]);
            end
            ST_ADDR_LO:
            begin
                emit_byte = head.target_address[7:0];
                crc_next  = crc_feed(crc_reg, head.target_address[7:0]);
            end
            ST_DATA:
            begin
                emit_byte = head.payload_byte;
                crc_next  = crc_feed(crc_reg, head.payload_byte);
                emit_last = !head.close_frame;
            end
            ST_CRC_HI:  emit_byte = crc_reg[15:8];
            ST_CRC_LO:
            begin
                emit_byte = crc_reg[7:0];
                crc_next  = CRC_INIT;
                emit_last = 1'b1;
                emit_end  = 1'b1;
            end
            default:    emit_byte = FRAME_ZERO;
        endcase
    end

    assign valid_next = emit ? 1'b1 : (frame_chan.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= ST_BEGIN;
            crc_reg   <= CRC_INIT;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
            if (emit)
                crc_reg <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg <= emit_byte;
            last_reg <= emit_last;
            end_reg  <= emit_end;
        end
    end

    assign frame_chan.valid     = valid_reg;
    assign frame_chan.out_byte  = byte_reg;
    assign frame_chan.run_last  = last_reg;
    assign frame_chan.frame_end = end_reg;

endmodule

`default_nettype wire

### design/write_command_framer_crc16.sv
// ============================================================================
// write_command_framer_crc16
// Builds write-command frames with a CRC-16 XModem trailer from payload beats.
// ============================================================================
//
//   channel     dir   beat contents
//   ----------  ----  ------------------------------------------------
//   data_chan   in    payload_byte, frame_length, target_address
//   frame_chan  out   out_byte, run_last, frame_end
//
// Mid-frame payload beats flow at one beat per cycle while the queue has room.
// The sequencer emits one frame byte per cycle unless the output stalls; an
// opening beat yields 7 bytes, a closing one 3, and a one-byte frame 9.
// Reset clears the open-frame count, the CRC, the queue and the output stage.
// A queue of QUEUE_DEPTH beats lets the input keep taking beats while the
// sequencer is busy with a header or trailer or the output is stalled.
// ============================================================================
`default_nettype none

module write_command_framer_crc16 #(
    parameter int QUEUE_DEPTH = wcf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    wcf_in_if.sink      data_chan,
    wcf_out_if.source   frame_chan
);
    import wcf_pkg::*;

    wcf_cmd_t   front_cmd;
    wcf_cmd_t   head_cmd;
    logic       push;
    logic       pop;
    logic       queue_empty;
    logic       queue_full;
    logic       frame_open;

    wcf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_chan  (data_chan),
        .queue_full (queue_full),
        .cmd        (front_cmd),
        .push       (push),
        .frame_open (frame_open)
    );

    wcf_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head     (head_cmd),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    wcf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_cmd),
        .empty      (queue_empty),
        .pop        (pop),
        .frame_chan (frame_chan)
    );

    // The CRC low byte always ends the work of the beat that caused it.
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_chan.valid && frame_chan.frame_end) |-> frame_chan.run_last)
        else $error("frame end without run_last");

    // A beat classified as closing leaves no frame open behind it.
    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (push && front_cmd.close_frame) |=> !frame_open)
        else $error("frame still open after closing beat");

    // A beat classified as continuing keeps the frame open.
    a_open_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !front_cmd.close_frame) |=> frame_open)
        else $error("frame closed early");

    // The sequencer never retires a beat from an empty queue.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !queue_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

### sim/wcf_frame_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// wcf_frame_checker
// Watches both channels of the framer, predicts the frame bytes that every
// accepted payload beat should cause, and compares them in order with the
// frame bytes that leave the block. Mismatches are counted for the top.
// ============================================================================

module wcf_frame_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    wcf_in_if         data_mon,
    wcf_out_if        frame_mon,
    output int        fail_count,
    output int        pending_results
);

    import wcf_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       run_last;
        logic       frame_end;
    } frame_byte_t;

    frame_byte_t frame_bytes_due[$];
    logic [8:0]  payload_left;
    logic [15:0] crc_acc;

    initial fail_count = 0;

    // Bit-serial form of the XModem CRC: each data bit, MSB first, is folded
    // into the feedback of the shift register.
    function automatic logic [15:0] crc_xmodem_byte(input logic [15:0] crc,
                                                    input logic [7:0]  data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ data[i];
            c  = {c[14:0], 1'b0};
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    task automatic predict_frame_bytes(input logic [7:0]  data,
                                       input logic [8:0]  len_in,
                                       input logic [15:0] addr);
        logic [7:0]  vals [9];
        logic        ends [9];
        logic [7:0]  hdr  [4];
        logic [8:0]  len;
        frame_byte_t fb;
        int          n;
        n = 0;
        if (payload_left == 9'd0)
        begin
            len = len_in;
            if (len == 9'd0)
                len = 9'd1;
            if (len > MAX_PAYLOAD)
                len = MAX_PAYLOAD;
            hdr[0] = FRAME_TYPE_WR;
            hdr[1] = len[7:0];
            hdr[2] = addr[15:8];
            hdr[3] = addr[7:0];
            vals[0] = FRAME_START;
            ends[0] = 1'b0;
            vals[1] = FRAME_ZERO;
            ends[1] = 1'b0;
            n = 2;
            crc_acc = CRC_INIT;
            for (int k = 0; k < 4; k++)
            begin
                vals[n] = hdr[k];
                ends[n] = 1'b0;
                n++;
                crc_acc = crc_xmodem_byte(crc_acc, hdr[k]);
            end
            payload_left = len;
        end
        vals[n] = data;
        ends[n] = 1'b0;
        n++;
        crc_acc = crc_xmodem_byte(crc_acc, data);
        payload_left = payload_left - 9'd1;
        // The last payload byte of a frame pulls the CRC trailer along.
        if (payload_left == 9'd0)
        begin
            vals[n] = crc_acc[15:8];
            ends[n] = 1'b0;
            n++;
            vals[n] = crc_acc[7:0];
            ends[n] = 1'b1;
            n++;
            crc_acc = CRC_INIT;
        end
        for (int k = 0; k < n; k++)
        begin
            fb.value     = vals[k];
            fb.run_last  = (k == n - 1);
            fb.frame_end = ends[k];
            frame_bytes_due.push_back(fb);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_byte_t want;
        if (!rst_n)
        begin
            payload_left = 9'd0;
            crc_acc      = CRC_INIT;
            frame_bytes_due.delete();
            pending_results = 0;
        end
        else
        begin
            if (data_mon.valid === 1'b1 && data_mon.ready === 1'b1)
                predict_frame_bytes(data_mon.payload_byte, data_mon.frame_length,
                                    data_mon.target_address);
            if (frame_mon.valid === 1'b1 && frame_mon.ready === 1'b1)
            begin
                if (frame_bytes_due.size() == 0)
                    report_mismatch("frame byte with none expected",
                                    frame_mon.out_byte, 8'h00);
                else
                begin
                    want = frame_bytes_due.pop_front();
                    if (frame_mon.out_byte !== want.value)
                        report_mismatch("out_byte", frame_mon.out_byte, want.value);
                    if (frame_mon.run_last !== want.run_last)
                        report_mismatch("run_last", {7'd0, frame_mon.run_last},
                                        {7'd0, want.run_last});
                    if (frame_mon.frame_end !== want.frame_end)
                        report_mismatch("frame_end", {7'd0, frame_mon.frame_end},
                                        {7'd0, want.frame_end});
                end
            end
            pending_results = frame_bytes_due.size();
        end
    end

endmodule

### sim/tb_write_command_framer_crc16.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_write_command_framer_crc16
// Drives payload beats grouped into frames of directed and random lengths
// into the framer, with random gaps on the input and random stalls on the
// output, and gives the verdict from the checker's mismatch and pending counts.
// ============================================================================

module tb_write_command_framer_crc16;

    import wcf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_BEATS  = 30;
    localparam int SETTLE_CYCLES = 20;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_kind_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_results;
    int   cycle_count = 0;
    int   beats_sent  = 0;
    bit   send_calm   = 1'b0;
    bit   recv_calm   = 1'b0;

    wcf_in_if  data_if ();
    wcf_out_if frame_if ();

    write_command_framer_crc16 uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_chan  (data_if),
        .frame_chan (frame_if)
    );

    wcf_frame_checker frame_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .data_mon        (data_if),
        .frame_mon       (frame_if),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_write_command_framer_crc16 NOT OK");
            $finish;
        end
    end

    function automatic int pick_gap(input bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_beat(input logic [7:0] data, input logic [8:0] len,
                             input logic [15:0] addr);
        int gap;
        if ($urandom_range(0, 29) == 0)
            send_calm = !send_calm;
        gap = pick_gap(send_calm);
        if (gap > 0)
        begin
            data_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        data_if.valid          <= 1'b1;
        data_if.payload_byte   <= data;
        data_if.frame_length   <= len;
        data_if.target_address <= addr;
        do
            @(posedge clk);
        while (data_if.ready !== 1'b1);
        @(negedge clk);
        beats_sent++;
    endtask

    task automatic send_frame(input logic [8:0] len_field, input logic [15:0] addr,
                              input fill_kind_t fill);
        int         beats;
        logic [7:0] data;
        beats = (len_field == 9'd0) ? 1 : (len_field > MAX_PAYLOAD) ? 256 : len_field;
        for (int k = 0; k < beats; k++)
        begin
            case (fill)
                FILL_ZERO: data = 8'h00;
                FILL_ONES: data = 8'hFF;
                default:   data = 8'($urandom);
            endcase
            // Length and address on the later beats must be ignored.
            if (k == 0)
                send_beat(data, len_field, addr);
            else
                send_beat(data, 9'($urandom_range(0, 511)), 16'($urandom));
        end
    endtask

    task automatic hold_until_drained();
        data_if.valid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int gap;
        frame_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                recv_calm = !recv_calm;
            gap = pick_gap(recv_calm);
            if (gap > 0)
            begin
                frame_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            frame_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (frame_if.valid !== 1'b1);
            @(negedge clk);
        end
    end

    initial
    begin
        int         pick;
        logic [8:0] len_field;
        fill_kind_t fill;
        rst_n                  <= 1'b0;
        data_if.valid          <= 1'b0;
        data_if.payload_byte   <= 8'h00;
        data_if.frame_length   <= 9'd0;
        data_if.target_address <= 16'h0000;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames: single-byte frames at the field extremes, a zero
        // length that must be taken as one, and short frames of fixed and random fill.
        send_frame(9'd1, 16'h0000, FILL_ZERO);
        send_frame(9'd1, 16'hFFFF, FILL_ONES);
        send_frame(9'd0, 16'h1234, FILL_RANDOM);
        send_frame(9'd2, 16'hA5A5, FILL_RANDOM);
        send_frame(9'd3, 16'h00FF, FILL_ONES);
        send_frame(9'd4, 16'hFF00, FILL_ZERO);
        send_frame(9'd8, 16'($urandom), FILL_RANDOM);
        hold_until_drained();

        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                len_field = 9'd0;
            else if (pick < 75)
                len_field = 9'($urandom_range(1, 6));
            else if (pick < 95)
                len_field = 9'($urandom_range(7, 20));
            else
                len_field = 9'($urandom_range(21, 64));
            pick = $urandom_range(0, 9);
            fill = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_ONES : FILL_RANDOM;
            send_frame(len_field, 16'($urandom), fill);
            if ($urandom_range(0, 11) == 0)
                hold_until_drained();
        end

        // One full-size frame, asked for either exactly or by a saturating
        // length; its length byte goes out as zero.
        if ($urandom_range(0, 1) == 0)
            len_field = MAX_PAYLOAD;
        else
            len_field = 9'($urandom_range(257, 511));
        send_frame(len_field, 16'($urandom), FILL_RANDOM);
        send_frame(9'($urandom_range(1, 4)), 16'($urandom), FILL_RANDOM);

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("tb_write_command_framer_crc16 OK");
        else
            $display("tb_write_command_framer_crc16 NOT OK");
        $finish;
    end

endmodule
